@@ design/rwms_pkg.sv @@
package rwms_pkg;

    localparam int DEF_MAX_RAYS = 512;
    localparam int DEF_MAX_BINS = 512;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_MISSING = 3'd0;
    localparam logic [2:0] REG_MIN_GOOD = 3'd1;
    localparam logic [2:0] REG_STD_LIMIT = 3'd2;
    localparam logic [2:0] REG_RAYS = 3'd3;
    localparam logic [2:0] REG_BINS = 3'd4;

    localparam logic [1:0] WST_COMPUTED = 2'd0;
    localparam logic [1:0] WST_FEW = 2'd1;
    localparam logic [1:0] WST_RANGE = 2'd2;

    // accumulator widths: count up to 2^24, sum 16+25, sumsq 32+24
    localparam int CNT_W = 25;
    localparam int SUM_W = 41;
    localparam int SQ_W = 56;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0] sumsq;
    } acc_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_DRAIN, ST_CHECK, ST_MATH, ST_MATH_WAIT, ST_OUT
    } state_t;

endpackage

@@ design/rwms_ram.sv @@
module rwms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/rwms_stats.sv @@
// Iterative mean and deviation unit. Divides sum by n with a restoring
// divider (one bit a cycle), forms num = |n*sumsq - sum^2| and den = n*(n-1)
// with 32x32 partial products over cycles, then a 16-step root search
// checks cand^2*den <= num, each check built from partial products.
module rwms_stats (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rwms_pkg::acc_t       acc,
    output logic                 done,
    output logic signed [15:0]   mean,
    output logic [15:0]          deviation
);
    import rwms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MUL, S_ROOT, S_DONE
    } ms_t;

    ms_t st_reg, st_next;

    // multiplier operand sequencing: product of a (64b) by b (64b) over 4 steps
    logic [63:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [127:0] macc_reg, macc_next;
    logic [1:0] mstep_reg, mstep_next;
    logic [2:0] job_reg, job_next;
    logic [31:0] pp_a, pp_b;
    logic [63:0] pp;
    logic [127:0] pp_shift;

    logic [SUM_W-1:0] aquo_reg, aquo_next, asum_w;
    logic [CNT_W:0] rem_reg, rem_next, rem_try;
    logic [5:0] dcnt_reg, dcnt_next;
    logic neg_reg, neg_next;

    logic [127:0] t1_reg, t1_next;   // n*sumsq, later num
    logic [63:0] den_reg, den_next;
    logic [15:0] dev_reg, dev_next, cand;
    logic [4:0] bit_reg, bit_next;
    logic signed [SUM_W-1:0] q_signed;

    assign asum_w = acc.sum[SUM_W-1] ? SUM_W'(-acc.sum) : SUM_W'(acc.sum);
    assign pp_a = mstep_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
    assign pp_b = mstep_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp = pp_a * pp_b;
    assign pp_shift = 128'(pp) << (32 * (32'(mstep_reg[0]) + 32'(mstep_reg[1])));
    assign rem_try = {rem_reg[CNT_W-1:0], aquo_reg[SUM_W-1]};
    assign cand = dev_reg | (16'd1 << bit_reg[3:0]);
    assign q_signed = neg_reg ? -$signed(aquo_reg) : $signed(aquo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        macc_reg <= macc_next;
        mstep_reg <= mstep_next;
        job_reg <= job_next;
        aquo_reg <= aquo_next;
        rem_reg <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg <= neg_next;
        t1_reg <= t1_next;
        den_reg <= den_next;
        dev_reg <= dev_next;
        bit_reg <= bit_next;
    end

    // sequence division, products and root search
    always_comb
    begin
        st_next = st_reg;
        ma_next = ma_reg;
        mb_next = mb_reg;
        macc_next = macc_reg;
        mstep_next = mstep_reg;
        job_next = job_reg;
        aquo_next = aquo_reg;
        rem_next = rem_reg;
        dcnt_next = dcnt_reg;
        neg_next = neg_reg;
        t1_next = t1_reg;
        den_next = den_reg;
        dev_next = dev_reg;
        bit_next = bit_reg;
        done = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    aquo_next = asum_w;
                    neg_next = acc.sum[SUM_W-1];
                    rem_next = '0;
                    dcnt_next = 6'(SUM_W);
                    st_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // shift one quotient bit a cycle
                if (rem_try >= {1'b0, acc.n})
                begin
                    rem_next = rem_try - {1'b0, acc.n};
                    aquo_next = {aquo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try;
                    aquo_next = {aquo_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd1)
                begin
                    job_next = 3'd0;
                    ma_next = 64'(acc.n);
                    mb_next = 64'(acc.sumsq);
                    macc_next = '0;
                    mstep_next = '0;
                    st_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // accumulate one 32x32 partial product a cycle
                macc_next = macc_reg + pp_shift;
                mstep_next = mstep_reg + 2'd1;
                if (mstep_reg == 2'd3)
                begin
                    mstep_next = '0;
                    unique case (job_reg)
                        3'd0:
                        begin
                            t1_next = macc_next;
                            ma_next = 64'(asum_w);
                            mb_next = 64'(asum_w);
                            macc_next = '0;
                            job_next = 3'd1;
                        end
                        3'd1:
                        begin
                            t1_next = (t1_reg >= macc_next) ? t1_reg - macc_next
                                                             : macc_next - t1_reg;
                            ma_next = 64'(acc.n);
                            mb_next = 64'(acc.n) - 64'd1;
                            macc_next = '0;
                            job_next = 3'd2;
                        end
                        3'd2:
                        begin
                            den_next = macc_next[63:0];
                            dev_next = '0;
                            bit_next = 5'd15;
                            ma_next = 64'(32'(16'd1 << 15) * 32'(16'd1 << 15));
                            mb_next = macc_next[63:0];
                            macc_next = '0;
                            job_next = 3'd3;
                        end
                        default:
                        begin
                            // root trial: cand^2 * den <= num
                            if (macc_next <= t1_reg)
                            begin
                                dev_next = cand;
                            end
                            if (bit_reg == 5'd0)
                            begin
                                st_next = S_DONE;
                            end
                            else
                            begin
                                bit_next = bit_reg - 5'd1;
                                st_next = S_ROOT;
                            end
                            macc_next = '0;
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                // form the next candidate square
                ma_next = 64'(cand) * 64'(cand);
                mb_next = den_reg;
                st_next = S_MUL;
            end
            S_DONE:
            begin
                done = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign mean = q_signed[15:0];
    assign deviation = dev_reg;
endmodule

@@ design/radar_window_mean_stddev.sv @@
// Windowed mean and standard deviation over one stored sweep.
// Sample write: one transfer per cycle while idle with no result pending, no result.
// Query: result valid in the cycle after the transfer if out of range; after scan, drain
// and check if too few are good (check alone for an empty bin span); else also after the
// stats divide, products, candidates and done. The next transfer waits for the result.
// Reset clears control state and configuration registers; the sample store is undefined.
module radar_window_mean_stddev #(
    parameter int MAX_RAYS = rwms_pkg::DEF_MAX_RAYS,
    parameter int MAX_BINS = rwms_pkg::DEF_MAX_BINS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_ray, sample_bin, sample_value, start_ray, end_ray,
    // first_bin, last_bin (bits 0..69), zero pad to 72
    input  logic [71:0] s_tdata,
    // op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mean, deviation, success, good_count (0..51), pad to 56
    output logic [55:0] m_tdata,
    // window_status
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [18:0] cfg_wdata
);
    import rwms_pkg::*;

    localparam int RW = $clog2(MAX_RAYS);
    localparam int BW = $clog2(MAX_BINS);
    localparam int AW = RW + BW;

    logic [15:0] missing_reg;
    logic [18:0] min_good_reg;
    logic [15:0] std_limit_reg;
    logic [9:0] rays_reg, bins_reg;

    state_t st_reg, st_next;
    logic [8:0] er_reg, fb_reg, lb_reg;
    logic [8:0] ray_reg, ray_next, bin_reg, bin_next;
    logic rd_vld_reg, rd_vld_next;
    acc_t acc_reg, acc_next;
    logic [53:0] out_reg, out_next;
    logic outv_reg, outv_next;

    logic op;
    logic [8:0] w_ray, w_bin, q_sr, q_er, q_fb, q_lb;
    logic [15:0] w_val, rdata;
    logic [10:0] nr, nb;
    logic we, oor, last_cell;
    logic [AW-1:0] raddr, waddr;
    logic start;
    logic done;
    logic signed [15:0] mean_w;
    logic [15:0] dev_w;
    logic signed [31:0] sq;
    logic [18:0] need;

    assign op = s_tuser;
    assign w_ray = s_tdata[8:0];
    assign w_bin = s_tdata[17:9];
    assign w_val = s_tdata[33:18];
    assign q_sr = s_tdata[42:34];
    assign q_er = s_tdata[51:43];
    assign q_fb = s_tdata[60:52];
    assign q_lb = s_tdata[69:61];

    assign nr = (32'(rays_reg) < MAX_RAYS) ? 11'(rays_reg) : 11'(MAX_RAYS);
    assign nb = (32'(bins_reg) < MAX_BINS) ? 11'(bins_reg) : 11'(MAX_BINS);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            missing_reg <= 16'h8000;
            min_good_reg <= 19'd5;
            std_limit_reg <= 16'd1600;
            rays_reg <= 10'd360;
            bins_reg <= 10'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MISSING: missing_reg <= cfg_wdata[15:0];
                REG_MIN_GOOD: min_good_reg <= cfg_wdata;
                REG_STD_LIMIT: std_limit_reg <= cfg_wdata[15:0];
                REG_RAYS: rays_reg <= cfg_wdata[9:0];
                REG_BINS: bins_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (st_reg == ST_IDLE) && !outv_reg;
    assign we = s_tvalid && s_tready && (op == OP_WRITE)
                && (32'(w_ray) < MAX_RAYS) && (32'(w_bin) < MAX_BINS);
    assign waddr = (AW'(w_ray) << BW) | AW'(w_bin);
    assign raddr = (AW'(ray_reg) << BW) | AW'(bin_reg);

    rwms_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(w_val),
        .raddr(raddr), .rdata(rdata)
    );

    rwms_stats u_stats (
        .clk(clk), .rst_n(rst_n), .start(start), .acc(acc_reg),
        .done(done), .mean(mean_w), .deviation(dev_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            outv_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            outv_reg <= outv_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            er_reg <= q_er;
            fb_reg <= q_fb;
            lb_reg <= q_lb;
        end
        ray_reg <= ray_next;
        bin_reg <= bin_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign sq = $signed(rdata) * $signed(rdata);
    assign last_cell = (bin_reg == lb_reg) && (ray_reg == er_reg);
    assign oor = (11'(q_fb) >= nb) || (11'(q_lb) >= nb)
                 || (11'(q_sr) >= nr) || (11'(q_er) >= nr);
    assign need = (min_good_reg < 19'd2) ? 19'd2 : min_good_reg;

    // check range, walk the window, accumulate, then report too few or hand off to the stats unit
    always_comb
    begin
        st_next = st_reg;
        ray_next = ray_reg;
        bin_next = bin_reg;
        rd_vld_next = 1'b0;
        acc_next = acc_reg;
        out_next = out_reg;
        outv_next = outv_reg;
        start = 1'b0;
        if (outv_reg && m_tready)
        begin
            outv_next = 1'b0;
        end
        // fold in the sample read last cycle
        if (rd_vld_reg && (rdata != missing_reg))
        begin
            acc_next.n = acc_reg.n + CNT_W'(1);
            acc_next.sum = acc_reg.sum + SUM_W'(signed'(rdata));
            acc_next.sumsq = acc_reg.sumsq + SQ_W'(unsigned'(sq));
        end
        unique case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready && op == OP_QUERY)
                begin
                    acc_next = '0;
                    ray_next = q_sr;
                    bin_next = q_fb;
                    if (oor)
                    begin
                        out_next = {WST_RANGE, 19'd0, 1'b0, 16'd0, missing_reg};
                        outv_next = 1'b1;
                    end
                    else if (q_fb > q_lb)
                    begin
                        st_next = ST_CHECK;
                    end
                    else
                    begin
                        st_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_vld_next = 1'b1;
                if (last_cell)
                begin
                    st_next = ST_DRAIN;
                end
                else if (bin_reg == lb_reg)
                begin
                    bin_next = fb_reg;
                    ray_next = (11'(ray_reg) + 11'd1 >= nr) ? 9'd0 : ray_reg + 9'd1;
                end
                else
                begin
                    bin_next = bin_reg + 9'd1;
                end
            end
            ST_DRAIN:
            begin
                st_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rd_vld_reg)
                begin
                    if (acc_reg.n < CNT_W'(need))
                    begin
                        out_next = {WST_FEW, acc_reg.n[18:0], 1'b1, 16'd0, missing_reg};
                        outv_next = 1'b1;
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        start = 1'b1;
                        st_next = ST_MATH_WAIT;
                    end
                end
            end
            ST_MATH_WAIT:
            begin
                if (done)
                begin
                    out_next = {WST_COMPUTED, acc_reg.n[18:0],
                                dev_w <= std_limit_reg, dev_w, mean_w};
                    outv_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = outv_reg;
    assign m_tdata = {4'b0, out_reg[51:0]};
    assign m_tuser = out_reg[53:52];
endmodule

@@ dv/tb.sv @@
module tb;
    import rwms_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 300;

    typedef struct {
        logic [15:0] mean;
        logic [15:0] dev;
        logic        ok;
        logic [18:0] cnt;
        logic [1:0]  st;
    } window_stats_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_MISSING;
    logic [18:0] cfg_wdata = '0;

    // shadow registers and sweep
    logic [15:0] sh_missing;
    logic [18:0] sh_min_good;
    logic [15:0] sh_limit;
    logic [9:0]  sh_rays;
    logic [9:0]  sh_bins;
    logic [15:0] sweep [0:DEF_MAX_RAYS*DEF_MAX_BINS-1];
    bit          loaded [0:DEF_MAX_RAYS*DEF_MAX_BINS-1];

    // op in the top bit, tdata below
    logic [72:0]   pending_items [$];
    window_stats_t expected_stats [$];

    int cyc = 0;
    int sent = 0;
    int n_queries = 0;
    int n_writes = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_computed = 0;
    int n_few = 0;
    int n_range = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    radar_window_mean_stddev dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // compute the window statistics from the shadow sweep
    function automatic window_stats_t window_stats(int sr, int er, int fb, int lb);
        window_stats_t res;
        longint n;
        longint sum;
        longint unsigned sumsq;
        longint unsigned asum;
        longint v;
        longint need;
        logic [127:0] num;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] den;
        logic [127:0] prod;
        logic [15:0] dev;
        logic [15:0] cand;
        int r;
        int nr;
        int nb;
        n = 0;
        sum = 0;
        sumsq = 0;
        nr = (sh_rays > DEF_MAX_RAYS) ? DEF_MAX_RAYS : sh_rays;
        nb = (sh_bins > DEF_MAX_BINS) ? DEF_MAX_BINS : sh_bins;
        res.mean = sh_missing;
        res.dev = '0;
        res.ok = 1'b0;
        res.cnt = '0;
        res.st = WST_RANGE;
        if (fb >= nb || lb >= nb || sr >= nr || er >= nr)
            return res;
        r = sr;
        while (1)
        begin
            for (int bn = fb; bn <= lb; bn++)
            begin
                if (sweep[r*DEF_MAX_BINS+bn] != sh_missing)
                begin
                    v = longint'($signed(sweep[r*DEF_MAX_BINS+bn]));
                    n++;
                    sum += v;
                    sumsq += longint'(v * v);
                end
            end
            if (r == er)
                break;
            r = (r + 1 == nr) ? 0 : r + 1;
        end
        need = (sh_min_good < 2) ? 2 : longint'(sh_min_good);
        res.cnt = n[18:0];
        if (n < need)
        begin
            res.ok = 1'b1;
            res.st = WST_FEW;
            return res;
        end
        asum = (sum < 0) ? -sum : sum;
        a = 128'(n) * 128'(sumsq);
        b = 128'(asum) * 128'(asum);
        num = (a >= b) ? a - b : b - a;
        den = 128'(n) * 128'(n - 1);
        dev = '0;
        for (int bit_i = 15; bit_i >= 0; bit_i--)
        begin
            cand = dev | (16'd1 << bit_i);
            prod = 128'(cand) * 128'(cand) * den;
            if (prod <= num)
                dev = cand;
        end
        v = sum / n;
        res.mean = v[15:0];
        res.dev = dev;
        res.ok = (dev <= sh_limit);
        res.st = WST_COMPUTED;
        return res;
    endfunction

    function automatic logic [72:0] pack_item(logic op, int ray, int bn, logic [15:0] val,
                                              int sr, int er, int fb, int lb);
        logic [72:0] d;
        d = '0;
        d[72] = op;
        d[8:0] = ray[8:0];
        d[17:9] = bn[8:0];
        d[33:18] = val;
        d[42:34] = sr[8:0];
        d[51:43] = er[8:0];
        d[60:52] = fb[8:0];
        d[69:61] = lb[8:0];
        return d;
    endfunction

    function automatic logic [15:0] rand_velocity();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return sh_missing;
        if (pick < 4)
            return 16'($urandom);
        return 16'(1000 + $signed($urandom_range(0, 4000)) - 2000);
    endfunction

    task automatic push_write(int ray, int bn, logic [15:0] val);
        pending_items.push_back(pack_item(OP_WRITE, ray, bn, val, $urandom_range(0, 511),
            $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511)));
        sweep[ray*DEF_MAX_BINS+bn] = val;
        loaded[ray*DEF_MAX_BINS+bn] = 1'b1;
        n_writes++;
    endtask

    // load any unwritten sample of the window, then issue the query
    task automatic push_query(int sr, int er, int fb, int lb);
        window_stats_t res;
        int r;
        if (sr < sh_rays && er < sh_rays && fb < sh_bins && lb < sh_bins)
        begin
            r = sr;
            while (1)
            begin
                for (int bn = fb; bn <= lb; bn++)
                    if (!loaded[r*DEF_MAX_BINS+bn])
                        push_write(r, bn, rand_velocity());
                if (r == er)
                    break;
                r = (r + 1 == sh_rays) ? 0 : r + 1;
            end
        end
        res = window_stats(sr, er, fb, lb);
        pending_items.push_back(pack_item(OP_QUERY, $urandom_range(0, 511),
            $urandom_range(0, 511), 16'($urandom), sr, er, fb, lb));
        expected_stats.push_back(res);
        n_queries++;
    endtask

    task automatic random_query();
        int sr;
        int er;
        int fb;
        int lb;
        int t;
        if ($urandom_range(0, 99) < 12)
        begin
            sr = $urandom_range(0, 511);
            er = $urandom_range(0, 511);
            fb = $urandom_range(0, 511);
            lb = $urandom_range(0, 511);
            // keep a window that lands in range small
            if (sr < sh_rays && er < sh_rays && fb < sh_bins && lb < sh_bins)
            begin
                er = sr;
                if (lb > fb + 6)
                    lb = fb + 6;
            end
            push_query(sr, er, fb, lb);
            return;
        end
        sr = $urandom_range(0, sh_rays - 1);
        er = (sr + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3)))
             % sh_rays;
        fb = $urandom_range(0, sh_bins - 1);
        lb = fb + $urandom_range(0, 6);
        if (lb >= sh_bins)
            lb = sh_bins - 1;
        if ($urandom_range(0, 99) < 8)
        begin
            t = fb;
            fb = lb;
            lb = t;
        end
        push_query(sr, er, fb, lb);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [18:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MISSING:   sh_missing = val[15:0];
            REG_MIN_GOOD:  sh_min_good = val;
            REG_STD_LIMIT: sh_limit = val[15:0];
            REG_RAYS:      sh_rays = val[9:0];
            default:       sh_bins = val[9:0];
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_stats.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_all(logic [15:0] miss, logic [18:0] mg, logic [15:0] lim,
                           logic [9:0] nr, logic [9:0] nb);
        drain();
        write_reg(REG_MISSING, {3'b0, miss});
        write_reg(REG_MIN_GOOD, mg);
        write_reg(REG_STD_LIMIT, {3'b0, lim});
        write_reg(REG_RAYS, {9'b0, nr});
        write_reg(REG_BINS, {9'b0, nb});
    endtask

    task automatic random_phase(int items);
        int start;
        start = n_writes + n_queries;
        while (n_writes + n_queries - start < items)
        begin
            if ($urandom_range(0, 99) < 20)
                push_write($urandom_range(0, 511), $urandom_range(0, 511), rand_velocity());
            else
                random_query();
        end
    endtask

    // stimulus: directed part, then random phases under several settings
    initial
    begin
        sh_missing = 16'h8000;
        sh_min_good = 19'd5;
        sh_limit = 16'd1600;
        sh_rays = 10'd360;
        sh_bins = 10'd512;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_write(0, 0, 16'h7FFF);
        push_write(511, 511, 16'h8000);
        push_write(0, 1, 16'h8000);
        push_write(0, 2, 16'h0000);
        push_write(359, 0, 16'hFFFF);
        push_write(359, 1, 16'h7FFF);
        push_query(0, 0, 0, 2);
        push_query(359, 0, 0, 1);
        push_query(0, 0, 511, 511);
        push_query(360, 0, 0, 0);
        push_query(0, 511, 0, 0);
        push_query(0, 0, 2, 0);
        push_query(1, 3, 10, 14);
        push_query(358, 2, 500, 502);
        push_query(10, 10, 0, 511);
        push_query(20, 21, 100, 104);
        random_phase(170);

        set_all(16'h7FFF, 19'd2, 16'd0, 10'd512, 10'd512);
        push_query(511, 511, 511, 511);
        push_query(510, 1, 0, 3);
        push_query(511, 0, 509, 511);
        random_phase(230);

        set_all(16'h0000, 19'd262144, 16'd65535, 10'd1, 10'd1);
        push_query(0, 0, 0, 0);
        push_query(1, 0, 0, 0);
        push_query(0, 0, 0, 1);
        random_phase(130);

        set_all(16'($urandom), 19'd3, 16'($urandom_range(100, 3000)), 10'd16, 10'd32);
        random_phase(250);

        set_all(16'($urandom), 19'd4, 16'd300, 10'd512, 10'd8);
        random_phase(200);

        set_all(16'h8000, 19'd2, 16'd65535, 10'd7, 10'd512);
        random_phase(170);

        drain();
        $display("Covered %0d queries and %0d sample writes under six register settings;",
                 n_queries, n_writes);
        $display("results: %0d computed, %0d too few, %0d out of range, %0d mismatches",
                 n_computed, n_few, n_range, n_mismatch);
        if (n_mismatch == 0 && expected_stats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // input driver: bursts with random gaps, hold the item until transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                {s_tuser, s_tdata} <= {pending_items.pop_front(), 72'b0} >> 72;
                s_tvalid <= 1'b1;
                sent <= sent + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, once, so the block backs up
    always @(posedge clk)
    begin
        if (!hold_done && sent >= 700)
        begin
            hold_left <= 4000;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver stall pattern: mode chosen by bits 10:9 of the cycle counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 1)
            m_tready <= 1'b0;
        else
            case (cyc[10:9])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= cyc[2];
            endcase
    end

    // result monitor: compare each transfer with the oldest expected stats
    always @(posedge clk)
    begin
        window_stats_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_stats.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h status %0d", m_tdata[51:0], m_tuser);
            end
            else
            begin
                e = expected_stats.pop_front();
                case (e.st)
                    WST_COMPUTED: n_computed++;
                    WST_FEW:      n_few++;
                    default:      n_range++;
                endcase
                if (m_tdata[15:0] !== e.mean || m_tdata[31:16] !== e.dev
                    || m_tdata[32] !== e.ok || m_tdata[51:33] !== e.cnt
                    || m_tuser !== e.st)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $display("result %0d: exp mean %h dev %h ok %b cnt %0d st %0d,",
                                 n_results, e.mean, e.dev, e.ok, e.cnt, e.st);
                        $display("    got mean %h dev %h ok %b cnt %0d st %0d",
                                 m_tdata[15:0], m_tdata[31:16], m_tdata[32],
                                 m_tdata[51:33], m_tuser);
                    end
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_stats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

@@ files.f @@
design/rwms_pkg.sv
design/rwms_ram.sv
design/rwms_stats.sv
design/radar_window_mean_stddev.sv
dv/tb.sv
